// File: rtl/smrp_pkg.sv
package smrp_pkg;

    // Number of message index characters captured from a notice.
    localparam int INDEX_CHARS = 3;
    // Fill counter must hold INDEX_CHARS itself.
    localparam int FILL_W = $clog2(INDEX_CHARS + 1);

    localparam int PREFIX_LEN = 6;
    localparam int POS_W = 3;
    localparam int QUOTE_W = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_QUOTE_TARGET = 1'b0;
    localparam logic [QUOTE_W-1:0] QUOTE_TARGET_RESET = 4'd8;

    // Characters of interest.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Event kinds.
    localparam logic EV_READ_REQ = 1'b0;
    localparam logic EV_BODY = 1'b1;

    // Candidate mask bits.
    localparam int CAND_NOTICE = 0;
    localparam int CAND_REPLY = 1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NOTICE = 2'd1,
        MODE_REPLY = 2'd2
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic [7:0] char_third;
        logic [1:0] char_count;
        logic [7:0] body_byte;
        logic       body_last;
    } t_result;

    // Prefix characters: "+CMTI:" for the notice, "+CMGR:" for the reply.
    function automatic logic [7:0] prefix_char(input logic reply_sel,
                                               input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0: c = 8'h2B;
            3'd1: c = 8'h43;
            3'd2: c = 8'h4D;
            3'd3: c = reply_sel ? 8'h47 : 8'h54;
            3'd4: c = reply_sel ? 8'h52 : 8'h49;
            3'd5: c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/smrp_cfg.sv
module smrp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smrp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [smrp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [smrp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [smrp_pkg::QUOTE_W-1:0]       o_quote_target
);

    logic [smrp_pkg::QUOTE_W-1:0] r_quote_target;
    logic                         w_hit;

    // Word index is the address above the byte offset.
    assign w_hit = (paddr[2:2] == smrp_pkg::REG_QUOTE_TARGET);
    assign pready = 1'b1;

    // Register write on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_target <= smrp_pkg::QUOTE_TARGET_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_quote_target <= pwdata[smrp_pkg::QUOTE_W-1:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {{(smrp_pkg::CFG_DATA_W - smrp_pkg::QUOTE_W){1'b0}}, r_quote_target};
        end
    end

    assign o_quote_target = r_quote_target;

endmodule

// File: rtl/smrp_core.sv
module smrp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_byte,
    input  logic [smrp_pkg::QUOTE_W-1:0]  i_quote_target,
    output logic                          o_res_valid,
    output smrp_pkg::t_result             o_res
);

    localparam int N = smrp_pkg::INDEX_CHARS;
    localparam int FW = smrp_pkg::FILL_W;

    smrp_pkg::t_mode              r_mode, n_mode;
    logic [smrp_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [1:0]                   r_mask, n_mask;
    logic                         r_capturing, n_capturing;
    logic [7:0]                   r_store [N];
    logic [7:0]                   n_store [N];
    logic [FW-1:0]                r_fill, n_fill;
    logic [smrp_pkg::QUOTE_W-1:0] r_tally, n_tally;
    logic                         r_header_done, n_header_done;
    logic                         r_newline_seen, n_newline_seen;
    logic                         r_body_active, n_body_active;

    logic          w_newline;
    logic [FW-1:0] w_fill_inc;
    logic          w_cap_done;
    logic [7:0]    w_cap_store [N];
    logic [1:0]    w_cap_count;
    logic [1:0]    w_mask;

    assign w_newline = (i_byte == smrp_pkg::CHAR_NEWLINE);
    assign w_fill_inc = r_fill + FW'(1);

    // Index capture: the byte goes into the slot the fill count points at.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_cap_store[k] = r_store[k];
            if (!w_newline && r_fill == FW'(k)) begin
                w_cap_store[k] = i_byte;
            end
        end
    end

    // Capture ends on a newline or once every slot is filled.
    always_comb begin
        w_cap_done = w_newline || (w_fill_inc >= FW'(N));
        if (w_newline) begin
            w_cap_count = (r_fill > FW'(3)) ? 2'd3 : 2'(r_fill);
        end else begin
            w_cap_count = (w_fill_inc > FW'(3)) ? 2'd3 : 2'(w_fill_inc);
        end
    end

    // Prefix matching drops each candidate on its first mismatch.
    always_comb begin
        w_mask = r_mask;
        if (w_mask[smrp_pkg::CAND_NOTICE] && (r_pos >= 3'(smrp_pkg::PREFIX_LEN) ||
                i_byte != smrp_pkg::prefix_char(1'b0, r_pos))) begin
            w_mask[smrp_pkg::CAND_NOTICE] = 1'b0;
        end
        if (w_mask[smrp_pkg::CAND_REPLY] && (r_pos >= 3'(smrp_pkg::PREFIX_LEN) ||
                i_byte != smrp_pkg::prefix_char(1'b1, r_pos))) begin
            w_mask[smrp_pkg::CAND_REPLY] = 1'b0;
        end
    end

    // Next-state logic for one accepted byte.
    always_comb begin
        n_mode = r_mode;
        n_pos = r_pos;
        n_mask = r_mask;
        n_capturing = r_capturing;
        n_store = r_store;
        n_fill = r_fill;
        n_tally = r_tally;
        n_header_done = r_header_done;
        n_newline_seen = r_newline_seen;
        n_body_active = r_body_active;
        if (i_fire) begin
            unique case (r_mode)
                smrp_pkg::MODE_NOTICE: begin
                    if (r_capturing && w_cap_done) begin
                        n_capturing = 1'b0;
                        n_fill = '0;
                        n_mode = smrp_pkg::MODE_IDLE;
                    end else begin
                        if (r_capturing) begin
                            n_store = w_cap_store;
                            n_fill = w_fill_inc;
                        end
                        if (i_byte == smrp_pkg::CHAR_COMMA) begin
                            n_capturing = 1'b1;
                        end
                    end
                end
                smrp_pkg::MODE_REPLY: begin
                    if (r_header_done) begin
                        if (r_body_active) begin
                            if (w_newline) begin
                                n_tally = '0;
                                n_header_done = 1'b0;
                                n_newline_seen = 1'b0;
                                n_body_active = 1'b0;
                                n_mode = smrp_pkg::MODE_IDLE;
                            end
                        end else if (w_newline) begin
                            if (r_newline_seen) begin
                                n_body_active = 1'b1;
                            end
                            n_newline_seen = 1'b1;
                        end
                    end else if (r_tally >= i_quote_target) begin
                        n_header_done = 1'b1;
                        n_tally = '0;
                    end else if (i_byte == smrp_pkg::CHAR_QUOTE) begin
                        n_tally = r_tally + 4'd1;
                    end
                end
                default: begin
                    // Idle, and the unused mode code behaves the same way.
                    n_mask = w_mask;
                    n_pos = r_pos + 3'd1;
                    unique case (w_mask)
                        2'b01: begin
                            n_mode = smrp_pkg::MODE_NOTICE;
                            n_capturing = 1'b0;
                            n_fill = '0;
                            for (int k = 0; k < N; k++) begin
                                n_store[k] = smrp_pkg::CHAR_SPACE;
                            end
                            n_mask = 2'b11;
                            n_pos = '0;
                        end
                        2'b10: begin
                            n_mode = smrp_pkg::MODE_REPLY;
                            n_tally = '0;
                            n_header_done = 1'b0;
                            n_newline_seen = 1'b0;
                            n_body_active = 1'b0;
                            n_mask = 2'b11;
                            n_pos = '0;
                        end
                        2'b00: begin
                            n_mask = 2'b11;
                            n_pos = '0;
                        end
                        default: begin
                            n_mask = w_mask;
                        end
                    endcase
                end
            endcase
        end
    end

    // Result for the byte at hand.
    always_comb begin
        o_res_valid = 1'b0;
        o_res = '0;
        if (i_fire && r_mode == smrp_pkg::MODE_NOTICE && r_capturing && w_cap_done) begin
            o_res_valid = 1'b1;
            o_res.kind = smrp_pkg::EV_READ_REQ;
            o_res.char_first = w_cap_store[0];
            o_res.char_second = smrp_pkg::CHAR_SPACE;
            o_res.char_third = smrp_pkg::CHAR_SPACE;
            for (int k = 0; k < N; k++) begin
                if (k == 1) begin
                    o_res.char_second = w_cap_store[k];
                end
                if (k == 2) begin
                    o_res.char_third = w_cap_store[k];
                end
            end
            o_res.char_count = w_cap_count;
        end else if (i_fire && r_mode == smrp_pkg::MODE_REPLY && r_header_done &&
                r_body_active) begin
            o_res_valid = 1'b1;
            o_res.kind = smrp_pkg::EV_BODY;
            o_res.body_byte = i_byte;
            o_res.body_last = w_newline;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= smrp_pkg::MODE_IDLE;
            r_pos <= '0;
            r_mask <= 2'b11;
            r_capturing <= 1'b0;
            for (int k = 0; k < N; k++) begin
                r_store[k] <= smrp_pkg::CHAR_SPACE;
            end
            r_fill <= '0;
            r_tally <= '0;
            r_header_done <= 1'b0;
            r_newline_seen <= 1'b0;
            r_body_active <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_mask <= n_mask;
            r_capturing <= n_capturing;
            r_store <= n_store;
            r_fill <= n_fill;
            r_tally <= n_tally;
            r_header_done <= n_header_done;
            r_newline_seen <= n_newline_seen;
            r_body_active <= n_body_active;
        end
    end

    // A read request always returns the parser to idle.
    a_req_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == smrp_pkg::EV_READ_REQ |=> r_mode == smrp_pkg::MODE_IDLE)
        else $error("read request did not return to idle");

    // The last body byte closes the reply and clears its flags.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.body_last |=> r_mode == smrp_pkg::MODE_IDLE && !r_header_done
            && !r_body_active && !r_newline_seen)
        else $error("last body byte did not close the reply");

    // While a notice is open the fill count stays below the slot count.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == smrp_pkg::MODE_NOTICE |-> r_fill < FW'(N))
        else $error("index fill count out of range");

    // Body bytes only flow once the header is done.
    a_body_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_body_active |-> r_header_done && r_newline_seen)
        else $error("body active before header end");

endmodule

// File: rtl/smrp_out_stage.sv
module smrp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  smrp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output smrp_pkg::t_result o_res
);

    logic              r_valid;
    smrp_pkg::t_result r_res;

    // The slot can take a new word when empty or being drained.
    assign o_free = !r_valid || i_ready;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res = r_res;

endmodule

// File: rtl/sms_modem_response_parser.sv
// Channel   Direction  Handshake                 Payload
// rx        in         i_rx_valid / o_rx_ready   i_rx_byte
// event     out        o_ev_valid / i_ev_ready   o_event_kind, o_index_char_*, o_body_*
// config    in         APB psel / penable        paddr, pwdata, prdata
//
// One byte is accepted per cycle when the result side keeps up.
// A byte is registered at input, parsed against the parser state when the
// result slot is free; any result is visible from the result register.
// A stalled result register holds its word, stops the parse stage and, with a
// byte waiting, drops o_rx_ready; the stall reaches the input in the same cycle.
// Reset is synchronous and active low.
module sms_modem_response_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_ev_valid,
    input  logic                            i_ev_ready,
    output logic                            o_event_kind,
    output logic [7:0]                      o_index_char_first,
    output logic [7:0]                      o_index_char_second,
    output logic [7:0]                      o_index_char_third,
    output logic [1:0]                      o_index_char_count,
    output logic [7:0]                      o_body_byte,
    output logic                            o_body_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smrp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [smrp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [smrp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         w_fire;
    logic                         w_free;
    logic                         w_res_valid;
    smrp_pkg::t_result            w_res;
    smrp_pkg::t_result            w_out;
    logic [smrp_pkg::QUOTE_W-1:0] w_quote_target;

    // The parse stage advances whenever it holds a byte and the result slot is free.
    assign w_fire = r_in_valid && w_free;
    assign o_rx_ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    smrp_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_quote_target (w_quote_target)
    );

    smrp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_byte         (r_in_byte),
        .i_quote_target (w_quote_target),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    smrp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_ready (i_ev_ready),
        .o_free  (w_free),
        .o_valid (o_ev_valid),
        .o_res   (w_out)
    );

    // Result fields.
    assign o_event_kind = w_out.kind;
    assign o_index_char_first = w_out.char_first;
    assign o_index_char_second = w_out.char_second;
    assign o_index_char_third = w_out.char_third;
    assign o_index_char_count = w_out.char_count;
    assign o_body_byte = w_out.body_byte;
    assign o_body_last = w_out.body_last;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import smrp_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 7;
    localparam int PHASES = 8;
    localparam int PHASE_BYTES = 140;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Register addresses: index times four, plus one index with no register behind it.
    localparam logic [CFG_ADDR_W-1:0] ADDR_QUOTE_TARGET = CFG_ADDR_W'(4 * REG_QUOTE_TARGET);
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);

    // Prefix texts, first character in the top byte.
    localparam logic [8*PREFIX_LEN-1:0] NOTICE_TEXT = "+CMTI:";
    localparam logic [8*PREFIX_LEN-1:0] REPLY_TEXT = "+CMGR:";

    // Directed rows: the byte to send and, where it is obvious, the word it must produce.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    res;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_result NO_WORD = '0;
    localparam t_result REQ_EMPTY = '{kind: EV_READ_REQ, char_first: CHAR_SPACE,
        char_second: CHAR_SPACE, char_third: CHAR_SPACE, char_count: 2'd0,
        body_byte: 8'h00, body_last: 1'b0};
    localparam t_result REQ_FULL = '{kind: EV_READ_REQ, char_first: CHAR_COMMA,
        char_second: 8'hFF, char_third: 8'h00, char_count: 2'd3,
        body_byte: 8'h00, body_last: 1'b0};
    localparam t_result BODY_FF = '{kind: EV_BODY, char_first: 8'h00,
        char_second: 8'h00, char_third: 8'h00, char_count: 2'd0,
        body_byte: 8'hFF, body_last: 1'b0};
    localparam t_result BODY_END = '{kind: EV_BODY, char_first: 8'h00,
        char_second: 8'h00, char_third: 8'h00, char_count: 2'd0,
        body_byte: CHAR_NEWLINE, body_last: 1'b1};

    // Played with a quote target of one.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, NO_WORD},          // both prefixes fail at once
        '{"+", 1'b0, NO_WORD},
        '{"C", 1'b0, NO_WORD},
        '{"M", 1'b0, NO_WORD},
        '{"T", 1'b0, NO_WORD},            // notice taken before the prefix ends
        '{CHAR_COMMA, 1'b0, NO_WORD},
        '{CHAR_NEWLINE, 1'b1, REQ_EMPTY}, // newline with nothing captured
        '{"+", 1'b0, NO_WORD},
        '{"C", 1'b0, NO_WORD},
        '{"M", 1'b0, NO_WORD},
        '{"T", 1'b0, NO_WORD},
        '{CHAR_COMMA, 1'b0, NO_WORD},
        '{CHAR_COMMA, 1'b0, NO_WORD},     // a comma while capturing is kept
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h00, 1'b1, REQ_FULL},
        '{"+", 1'b0, NO_WORD},
        '{"C", 1'b0, NO_WORD},
        '{"M", 1'b0, NO_WORD},
        '{"G", 1'b0, NO_WORD},
        '{CHAR_QUOTE, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},          // skipped byte after the last quote
        '{CHAR_NEWLINE, 1'b0, NO_WORD},
        '{CHAR_NEWLINE, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, BODY_FF},
        '{CHAR_NEWLINE, 1'b1, BODY_END}
    };

    // Block ports.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_rx_valid = 1'b0;
    logic                  o_rx_ready;
    logic [7:0]            i_rx_byte = 8'h00;
    logic                  o_ev_valid;
    logic                  i_ev_ready = 1'b0;
    logic                  o_event_kind;
    logic [7:0]            o_index_char_first;
    logic [7:0]            o_index_char_second;
    logic [7:0]            o_index_char_third;
    logic [1:0]            o_index_char_count;
    logic [7:0]            o_body_byte;
    logic                  o_body_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Parser state as the testbench sees it.
    t_mode      p_mode;
    logic [2:0] p_pos;
    logic [1:0] p_cand;
    bit         p_capture;
    logic [7:0] p_chars [INDEX_CHARS];
    int         p_nchars;
    logic [3:0] p_quotes;
    bit         p_hdr_done;
    bit         p_nl_seen;
    bit         p_in_body;
    logic [3:0] p_target;

    t_result    pending_events [$];
    logic [7:0] rx_script [$];
    t_result    ev_want;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent = 0;
    int         events_seen = 0;
    int         body_events = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         phase;
    int         row;
    int         phase_start;

    sms_modem_response_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_ev_valid          (o_ev_valid),
        .i_ev_ready          (i_ev_ready),
        .o_event_kind        (o_event_kind),
        .o_index_char_first  (o_index_char_first),
        .o_index_char_second (o_index_char_second),
        .o_index_char_third  (o_index_char_third),
        .o_index_char_count  (o_index_char_count),
        .o_body_byte         (o_body_byte),
        .o_body_last         (o_body_last),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words outstanding.",
                     cycle_count, pending_events.size());
            $display("[sms_modem_response_parser] ERROR");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        i_ev_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void clear_reply_state();
        p_quotes = '0;
        p_hdr_done = 1'b0;
        p_nl_seen = 1'b0;
        p_in_body = 1'b0;
    endfunction

    function automatic void start_notice();
        p_mode = MODE_NOTICE;
        p_capture = 1'b0;
        p_nchars = 0;
        for (int k = 0; k < INDEX_CHARS; k++) begin
            p_chars[k] = CHAR_SPACE;
        end
    endfunction

    function automatic void reset_parser_state();
        p_target = QUOTE_TARGET_RESET;
        p_pos = '0;
        p_cand = 2'b11;
        start_notice();
        p_mode = MODE_IDLE;
        clear_reply_state();
    endfunction

    // Advances the parser by one byte; returns 1 when the byte produces a word.
    function automatic bit parse_rx_byte(input logic [7:0] b, output t_result r);
        bit done;
        r = '0;
        done = 1'b0;
        if (p_mode == MODE_NOTICE) begin
            if (p_capture) begin
                if (b == CHAR_NEWLINE) begin
                    done = 1'b1;
                end else begin
                    if (p_nchars < INDEX_CHARS) p_chars[p_nchars] = b;
                    p_nchars++;
                    if (p_nchars >= INDEX_CHARS) done = 1'b1;
                end
                if (done) begin
                    r.kind = EV_READ_REQ;
                    r.char_first = p_chars[0];
                    r.char_second = INDEX_CHARS > 1 ? p_chars[1 % INDEX_CHARS] : CHAR_SPACE;
                    r.char_third = INDEX_CHARS > 2 ? p_chars[2 % INDEX_CHARS] : CHAR_SPACE;
                    r.char_count = p_nchars > 3 ? 2'd3 : 2'(p_nchars);
                    p_capture = 1'b0;
                    p_nchars = 0;
                    p_mode = MODE_IDLE;
                    return 1'b1;
                end
            end
            if (b == CHAR_COMMA) p_capture = 1'b1;
            return 1'b0;
        end

        if (p_mode == MODE_REPLY) begin
            if (p_hdr_done) begin
                if (p_in_body) begin
                    r.kind = EV_BODY;
                    r.body_byte = b;
                    r.body_last = (b == CHAR_NEWLINE);
                    if (b == CHAR_NEWLINE) begin
                        clear_reply_state();
                        p_mode = MODE_IDLE;
                    end
                    return 1'b1;
                end
                if (b == CHAR_NEWLINE) begin
                    if (p_nl_seen) p_in_body = 1'b1;
                    p_nl_seen = 1'b1;
                end
                return 1'b0;
            end
            // Once the quote count is reached, the next byte is dropped.
            if (p_quotes >= p_target) begin
                p_hdr_done = 1'b1;
                p_quotes = '0;
                return 1'b0;
            end
            if (b == CHAR_QUOTE) p_quotes = p_quotes + 4'd1;
            return 1'b0;
        end

        // Idle: both prefixes are tried in parallel.
        if (p_cand[CAND_NOTICE]) begin
            if (p_pos >= PREFIX_LEN || b != NOTICE_TEXT[8*(PREFIX_LEN-1-p_pos) +: 8])
                p_cand[CAND_NOTICE] = 1'b0;
        end
        if (p_cand[CAND_REPLY]) begin
            if (p_pos >= PREFIX_LEN || b != REPLY_TEXT[8*(PREFIX_LEN-1-p_pos) +: 8])
                p_cand[CAND_REPLY] = 1'b0;
        end
        p_pos = p_pos + 3'd1;
        if (p_cand == 2'b01) begin
            start_notice();
            p_cand = 2'b11;
            p_pos = '0;
        end else if (p_cand == 2'b10) begin
            p_mode = MODE_REPLY;
            clear_reply_state();
            p_cand = 2'b11;
            p_pos = '0;
        end else if (p_cand == 2'b00) begin
            p_cand = 2'b11;
            p_pos = '0;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Each word leaving the block is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_ev_valid && i_ev_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected word, expected none, got kind %b byte %h",
                         $time, o_event_kind, o_body_byte);
                mismatches++;
            end else begin
                ev_want = pending_events.pop_front();
                check_field("event_kind", 8'(ev_want.kind), 8'(o_event_kind));
                check_field("index_char_first", ev_want.char_first, o_index_char_first);
                check_field("index_char_second", ev_want.char_second, o_index_char_second);
                check_field("index_char_third", ev_want.char_third, o_index_char_third);
                check_field("index_char_count", 8'(ev_want.char_count),
                            8'(o_index_char_count));
                check_field("body_byte", ev_want.body_byte, o_body_byte);
                check_field("body_last", 8'(ev_want.body_last), 8'(o_body_last));
                events_seen++;
                if (ev_want.kind == EV_BODY) body_events++;
            end
        end
    end

    // Sends one byte; entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_res);
        t_result r;
        bit has_word;
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        has_word = parse_rx_byte(b, r);
        if (typed) pending_events.push_back(typed_res);
        else if (has_word) pending_events.push_back(r);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((addr >> 2) == REG_QUOTE_TARGET) p_target = data[QUOTE_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_QUOTE_TARGET;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[QUOTE_W-1:0] !== p_target) begin
            $display("%0t: quote target readback mismatch, expected %h, got %h",
                     $time, p_target, prdata[QUOTE_W-1:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lets every predicted word come out, then gives the pipeline time to empty.
    task automatic settle();
        i_rx_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            rx_script.push_back(s[k]);
        end
    endfunction

    // Random filler that never equals the given character.
    function automatic void push_filler(input int n, input logic [7:0] avoid);
        logic [7:0] c;
        for (int k = 0; k < n; k++) begin
            c = 8'($urandom_range(255));
            if (c == avoid) c = "a";
            rx_script.push_back(c);
        end
    endfunction

    // Builds one notice, reply or burst of noise with random content.
    function automatic void build_sequence();
        int pick;
        int n;
        int quotes;
        int cut;
        pick = $urandom_range(99);
        if (pick < 45) begin
            push_text("+CMT");
            if ($urandom_range(1)) push_text("I:");
            push_filler($urandom_range(0, 3), CHAR_COMMA);
            rx_script.push_back(CHAR_COMMA);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(9) < 7) rx_script.push_back(8'h30 + 8'($urandom_range(9)));
                else rx_script.push_back(8'($urandom_range(255)));
            end
            if (n < 3) rx_script.push_back(CHAR_NEWLINE);
        end else if (pick < 90) begin
            push_text("+CMG");
            if ($urandom_range(1)) push_text("R:");
            quotes = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : int'(p_target);
            for (int k = 0; k < quotes; k++) begin
                push_filler($urandom_range(0, 2), CHAR_QUOTE);
                rx_script.push_back(CHAR_QUOTE);
            end
            rx_script.push_back(8'($urandom_range(255)));
            push_filler($urandom_range(0, 4), CHAR_NEWLINE);
            rx_script.push_back(CHAR_NEWLINE);
            push_filler($urandom_range(0, 3), CHAR_NEWLINE);
            rx_script.push_back(CHAR_NEWLINE);
            push_filler($urandom_range(0, 12), CHAR_NEWLINE);
            rx_script.push_back(CHAR_NEWLINE);
        end else begin
            n = $urandom_range(0, 2);
            if (n == 1) push_text("+C");
            if (n == 2) push_text("+CM");
            push_filler($urandom_range(1, 6), 8'h00);
        end
        // A few sequences are cut short.
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, rx_script.size());
            while (rx_script.size() > cut) void'(rx_script.pop_back());
        end
    endfunction

    initial begin
        reset_parser_state();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value, a write to an unmapped index, a quote target of one, then the directed rows.
        check_register();
        write_register(ADDR_UNMAPPED, 32'h0000_0003);
        check_register();
        write_register(ADDR_QUOTE_TARGET, 32'h0000_0001);
        check_register();
        for (row = 0; row < DIR_ROWS; row++) begin
            send_byte(DIR_TABLE[row].rx, DIR_TABLE[row].typed, DIR_TABLE[row].res);
        end

        // Random phases: each sets a quote target and an idling pattern.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: write_register(ADDR_QUOTE_TARGET, 32'(QUOTE_TARGET_RESET));
                1: write_register(ADDR_QUOTE_TARGET, 32'd15);
                2: write_register(ADDR_QUOTE_TARGET, 32'd1);
                3: write_register(ADDR_QUOTE_TARGET, 32'd0);
                4: write_register(ADDR_QUOTE_TARGET, 32'hFFFF_FFFF);
                6: write_register(ADDR_QUOTE_TARGET, 32'd1);
                default: write_register(ADDR_QUOTE_TARGET, 32'($urandom_range(1, 15)));
            endcase
            check_register();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_sequence();
                while (rx_script.size() != 0) send_byte(rx_script.pop_front(), 1'b0, NO_WORD);
            end
        end

        settle();
        $display("Sent %0d bytes in a directed part and %0d random phases.", bytes_sent, PHASES);
        $display("Checked %0d words: %0d read requests and %0d body bytes.",
                 events_seen, events_seen - body_events, body_events);
        if (mismatches == 0) begin
            $display("[sms_modem_response_parser] OK");
        end else begin
            $display("[sms_modem_response_parser] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/smrp_pkg.sv
rtl/smrp_cfg.sv
rtl/smrp_core.sv
rtl/smrp_out_stage.sv
rtl/sms_modem_response_parser.sv
sim/testbench.sv
